### hw/rtl/gtm_pkg.sv
// ----------------------------------------------------------------------------
// gtm_pkg
// Shared types and constants of the global tone mapper.
// ----------------------------------------------------------------------------
package gtm_pkg;

  localparam int CH_W         = 14;
  localparam int CURVE_POINTS = 257;
  localparam int CURVE_AW     = 9;
  localparam int SEG_SHIFT    = 6;
  localparam int WEIGHT_SHIFT = 10;
  localparam int LUMA_ROUND   = 512;
  localparam int DROP_BITS    = 16 - 14;
  localparam int DIV_STAGES   = 14;
  localparam logic [CH_W-1:0] MAX14 = 14'h3FFF;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_CURVE = 1'b1;

  typedef enum logic [1:0] {
    REG_BYPASS  = 2'd0,
    REG_RED_W   = 2'd1,
    REG_GREEN_W = 2'd2,
    REG_BLUE_W  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } rgb_t;

endpackage

### hw/rtl/global_tone_map_rgb.sv
// ----------------------------------------------------------------------------
// global_tone_map_rgb
// Luma-ratio global tone mapping of an RGB stream with a loadable curve.
// ----------------------------------------------------------------------------
//  Channel | Direction | Carries
//  in_*    | input     | pixel (tuser 0) or curve point write (tuser 1)
//  out_*   | output    | one mapped pixel per input pixel
//  cfg_*   | APB       | bypass and luma weights
//
//  One transaction is accepted per cycle while in_tready is high; a pixel passes
//  the curve lookup and then the 14-stage quotient pipeline on its way to out_*.
//  The curve memory is read and written in one stage, so writes and pixels
//  take effect in stream order. Curve writes produce no output.
//  A skid register at the output holds one result when out_tready is low;
//  in_tready falls only once it is occupied. Reset is synchronous, active low.
module global_tone_map_rgb
  import gtm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // red[15:0], green[31:16], blue[47:32], curve_index[56:48], curve_value[70:57]
  input  logic [71:0] in_tdata,
  // kind
  input  logic        in_tuser,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // red_out[15:0], green_out[31:16], blue_out[47:32]
  output logic [47:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // Configuration registers.
  logic       bypass_r;
  logic [9:0] red_w_r, green_w_r, blue_w_r;
  reg_idx_t   cfg_idx;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bypass_r  <= 1'b0;
      red_w_r   <= 10'd306;
      green_w_r <= 10'd601;
      blue_w_r  <= 10'd117;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_BYPASS:  bypass_r  <= cfg_pwdata[0];
        REG_RED_W:   red_w_r   <= cfg_pwdata[9:0];
        REG_GREEN_W: green_w_r <= cfg_pwdata[9:0];
        REG_BLUE_W:  blue_w_r  <= cfg_pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_BYPASS:  cfg_prdata = {31'd0, bypass_r};
      REG_RED_W:   cfg_prdata = {22'd0, red_w_r};
      REG_GREEN_W: cfg_prdata = {22'd0, green_w_r};
      REG_BLUE_W:  cfg_prdata = {22'd0, blue_w_r};
      default:     cfg_prdata = 32'd0;
    endcase
  end

  // Pipeline enable: the whole pipeline holds while the skid register is full.
  logic skid_v_r;
  logic en;
  assign en        = ~skid_v_r;
  assign in_tready = en;

  // Stage A: input capture.
  logic                a_v_r, a_kind_r, a_last_r;
  rgb_t                a_rgb_r;
  logic [CURVE_AW-1:0] a_idx_r;
  logic [CH_W-1:0]     a_val_r;

  // Stage B: weighted products.
  logic                b_v_r, b_kind_r, b_last_r;
  rgb_t                b_rgb_r;
  logic [CURVE_AW-1:0] b_idx_r;
  logic [CH_W-1:0]     b_val_r;
  logic [23:0]         b_pr_r, b_pg_r, b_pb_r;

  // Stage C: luma.
  logic                c_v_r, c_kind_r, c_last_r;
  rgb_t                c_rgb_r;
  logic [CURVE_AW-1:0] c_idx_r;
  logic [CH_W-1:0]     c_val_r;
  logic [CH_W-1:0]     c_luma_r;
  logic [25:0]         c_sum;
  logic [15:0]         c_luma_wide;
  logic [CH_W-1:0]     c_luma_nxt;

  assign c_sum       = 26'(b_pr_r) + 26'(b_pg_r) + 26'(b_pb_r) + 26'(LUMA_ROUND);
  assign c_luma_wide = c_sum[25:WEIGHT_SHIFT];
  assign c_luma_nxt  = (c_luma_wide > 16'(MAX14)) ? MAX14 : c_luma_wide[CH_W-1:0];

  // Stage D: curve memory access.
  logic [CH_W-1:0]     curve_mem [0:CURVE_POINTS-1];
  logic [CH_W-1:0]     d_p0_r, d_p1_r;
  logic                d_v_r, d_last_r;
  rgb_t                d_rgb_r;
  logic [CH_W-1:0]     d_luma_r;
  logic [CURVE_AW-1:0] rd_a0, rd_a1;
  logic                curve_we;

  // Luma never exceeds 16383, so the upper point index stays at or below 256.
  assign rd_a0    = {1'b0, c_luma_r[CH_W-1:SEG_SHIFT]};
  assign rd_a1    = rd_a0 + 9'd1;
  assign curve_we = en & c_v_r & (c_kind_r == KIND_CURVE)
                  & (c_idx_r < 9'(CURVE_POINTS));

  always_ff @(posedge clk) begin
    if (curve_we) curve_mem[c_idx_r] <= c_val_r;
    if (en) begin
      d_p0_r <= curve_mem[rd_a0];
      d_p1_r <= curve_mem[rd_a1];
    end
  end

  // Stage E: slope times offset in the segment.
  logic                e_v_r, e_last_r;
  rgb_t                e_rgb_r;
  logic [CH_W-1:0]     e_luma_r, e_p0_r;
  logic signed [20:0]  e_prod_r;
  logic signed [14:0]  e_diff;
  logic signed [21:0]  e_prod_w;

  assign e_diff   = $signed({1'b0, d_p1_r}) - $signed({1'b0, d_p0_r});
  assign e_prod_w = $signed({1'b0, d_luma_r[SEG_SHIFT-1:0]}) * e_diff;

  // Stage F: mapped luma; the shift rounds toward zero for falling curves.
  logic                f_v_r, f_last_r;
  rgb_t                f_rgb_r;
  logic [CH_W-1:0]     f_luma_r, f_map_r;
  logic signed [20:0]  f_adj, f_step, f_sum;

  assign f_adj  = e_prod_r[20] ? (e_prod_r + 21'sd63) : e_prod_r;
  assign f_step = f_adj >>> SEG_SHIFT;
  assign f_sum  = $signed({7'd0, e_p0_r}) + f_step;

  // Stage G: channel times mapped luma.
  logic                g_v_r, g_last_r;
  rgb_t                g_rgb_r;
  logic [CH_W-1:0]     g_luma_r;
  logic [27:0]         g_m_r [0:2];

  // Divider stages: index 0 checks saturation, then one quotient bit per stage.
  logic [DIV_STAGES:0] dv_v_r;
  logic                dv_last_r [0:DIV_STAGES];
  logic                dv_zero_r [0:DIV_STAGES];
  logic [CH_W-1:0]     dv_luma_r [0:DIV_STAGES];
  logic [CH_W-1:0]     dv_ch_r   [0:DIV_STAGES][0:2];
  logic                dv_sat_r  [0:DIV_STAGES][0:2];
  logic [27:0]         dv_rem_r  [0:DIV_STAGES][0:2];
  logic [CH_W-1:0]     dv_q_r    [0:DIV_STAGES][0:2];
  logic [27:0]         dv_rem_nxt [0:DIV_STAGES][0:2];
  logic [CH_W-1:0]     dv_q_nxt   [0:DIV_STAGES][0:2];
  logic [CH_W-1:0]     g_ch [0:2];

  assign g_ch[0] = g_rgb_r.r;
  assign g_ch[1] = g_rgb_r.g;
  assign g_ch[2] = g_rgb_r.b;

  always_comb begin
    logic [27:0] trial;
    for (int l = 0; l < 3; l++) begin
      dv_rem_nxt[0][l] = g_m_r[l];
      dv_q_nxt[0][l]   = '0;
      for (int s = 1; s <= DIV_STAGES; s++) begin
        trial = {14'd0, dv_luma_r[s-1]} << (DIV_STAGES - s);
        dv_rem_nxt[s][l] = dv_rem_r[s-1][l];
        dv_q_nxt[s][l]   = dv_q_r[s-1][l];
        if (dv_rem_r[s-1][l] >= trial) begin
          dv_rem_nxt[s][l] = dv_rem_r[s-1][l] - trial;
          dv_q_nxt[s][l][DIV_STAGES - s] = 1'b1;
        end
      end
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r  <= 1'b0;
      b_v_r  <= 1'b0;
      c_v_r  <= 1'b0;
      d_v_r  <= 1'b0;
      e_v_r  <= 1'b0;
      f_v_r  <= 1'b0;
      g_v_r  <= 1'b0;
      dv_v_r <= '0;
    end else if (en) begin
      a_v_r  <= in_tvalid;
      b_v_r  <= a_v_r;
      c_v_r  <= b_v_r;
      d_v_r  <= c_v_r & (c_kind_r == KIND_PIXEL);
      e_v_r  <= d_v_r;
      f_v_r  <= e_v_r;
      g_v_r  <= f_v_r;
      dv_v_r <= {dv_v_r[DIV_STAGES-1:0], g_v_r};
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (en) begin
      a_kind_r  <= in_tuser;
      a_last_r  <= in_tlast;
      a_rgb_r.r <= in_tdata[15:DROP_BITS];
      a_rgb_r.g <= in_tdata[31:16+DROP_BITS];
      a_rgb_r.b <= in_tdata[47:32+DROP_BITS];
      a_idx_r   <= in_tdata[56:48];
      a_val_r   <= in_tdata[70:57];

      b_kind_r <= a_kind_r;
      b_last_r <= a_last_r;
      b_rgb_r  <= a_rgb_r;
      b_idx_r  <= a_idx_r;
      b_val_r  <= a_val_r;
      b_pr_r   <= 24'(a_rgb_r.r) * 24'(red_w_r);
      b_pg_r   <= 24'(a_rgb_r.g) * 24'(green_w_r);
      b_pb_r   <= 24'(a_rgb_r.b) * 24'(blue_w_r);

      c_kind_r <= b_kind_r;
      c_last_r <= b_last_r;
      c_rgb_r  <= b_rgb_r;
      c_idx_r  <= b_idx_r;
      c_val_r  <= b_val_r;
      c_luma_r <= c_luma_nxt;

      d_last_r <= c_last_r;
      d_rgb_r  <= c_rgb_r;
      d_luma_r <= c_luma_r;

      e_last_r <= d_last_r;
      e_rgb_r  <= d_rgb_r;
      e_luma_r <= d_luma_r;
      e_p0_r   <= d_p0_r;
      e_prod_r <= e_prod_w[20:0];

      f_last_r <= e_last_r;
      f_rgb_r  <= e_rgb_r;
      f_luma_r <= e_luma_r;
      f_map_r  <= f_sum[CH_W-1:0];

      g_last_r <= f_last_r;
      g_rgb_r  <= f_rgb_r;
      g_luma_r <= f_luma_r;
      g_m_r[0] <= 28'(f_rgb_r.r) * 28'(f_map_r);
      g_m_r[1] <= 28'(f_rgb_r.g) * 28'(f_map_r);
      g_m_r[2] <= 28'(f_rgb_r.b) * 28'(f_map_r);

      dv_last_r[0] <= g_last_r;
      dv_zero_r[0] <= (g_luma_r == '0);
      dv_luma_r[0] <= g_luma_r;
      for (int l = 0; l < 3; l++) begin
        dv_ch_r[0][l]  <= g_ch[l];
        dv_sat_r[0][l] <= (g_m_r[l] >= {g_luma_r, 14'd0});
        dv_rem_r[0][l] <= dv_rem_nxt[0][l];
        dv_q_r[0][l]   <= dv_q_nxt[0][l];
      end
      for (int s = 1; s <= DIV_STAGES; s++) begin
        dv_last_r[s] <= dv_last_r[s-1];
        dv_zero_r[s] <= dv_zero_r[s-1];
        dv_luma_r[s] <= dv_luma_r[s-1];
        for (int l = 0; l < 3; l++) begin
          dv_ch_r[s][l]  <= dv_ch_r[s-1][l];
          dv_sat_r[s][l] <= dv_sat_r[s-1][l];
          dv_rem_r[s][l] <= dv_rem_nxt[s][l];
          dv_q_r[s][l]   <= dv_q_nxt[s][l];
        end
      end
    end
  end

  // Result selection from the last divider stage.
  logic [CH_W-1:0] res_ch [0:2];
  logic [47:0]     res_data;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (bypass_r)
        res_ch[l] = dv_ch_r[DIV_STAGES][l];
      else if (dv_zero_r[DIV_STAGES])
        res_ch[l] = '0;
      else if (dv_sat_r[DIV_STAGES][l])
        res_ch[l] = MAX14;
      else
        res_ch[l] = dv_q_r[DIV_STAGES][l];
    end
  end

  assign res_data = {res_ch[2], 2'b00, res_ch[1], 2'b00, res_ch[0], 2'b00};

  // Output register with one skid entry.
  logic        out_v_r, out_last_r, skid_last_r;
  logic [47:0] out_data_r, skid_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_v_r && !out_tready) begin
      if (en && dv_v_r[DIV_STAGES]) skid_v_r <= 1'b1;
    end else if (skid_v_r) begin
      out_v_r  <= 1'b1;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r <= dv_v_r[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (out_v_r && !out_tready) begin
      if (en) begin
        skid_data_r <= res_data;
        skid_last_r <= dv_last_r[DIV_STAGES];
      end
    end else if (skid_v_r) begin
      out_data_r <= skid_data_r;
      out_last_r <= skid_last_r;
    end else begin
      out_data_r <= res_data;
      out_last_r <= dv_last_r[DIV_STAGES];
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

### hw/rtl/gtm_chk.sv
// ----------------------------------------------------------------------------
// gtm_chk
// Port-level checks of the global tone mapper, bound to the top level.
// ----------------------------------------------------------------------------
module gtm_chk
  import gtm_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tlast,
  input logic        cfg_psel,
  input logic        cfg_penable,
  input logic        cfg_pready
);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output transaction changed while stalled");

  // Every output channel is a 14-bit value shifted left, so the low bits are clear.
  a_low_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[DROP_BITS-1:0] == '0 && out_tdata[17:16] == '0
                   && out_tdata[33:32] == '0)
    else $error("output channel has low bits set");

  // The input side only stalls when a result is already waiting at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with an empty output");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("output not empty after reset");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable |-> cfg_pready)
    else $error("configuration access was not ready");

endmodule

bind global_tone_map_rgb gtm_chk u_gtm_chk (.*);

### tb/sv/tb_global_tone_map_rgb.sv
// ----------------------------------------------------------------------------
// tb_global_tone_map_rgb
// Self-checking bench for the luma-ratio global tone mapper. It drives pixels
// and curve-point writes on the input stream and programs bypass and weights
// over APB between phases. A bit-accurate predictor computes each expected
// pixel, and the bench compares it field by field with the output stream.
// Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_global_tone_map_rgb;
  import gtm_pkg::*;

  typedef struct packed {
    logic [15:0] r;
    logic [15:0] g;
    logic [15:0] b;
    logic        last;
  } pix_res_t;

  typedef struct {
    logic        kind;
    logic [15:0] r;
    logic [15:0] g;
    logic [15:0] b;
    logic        last;
    logic [8:0]  idx;
    logic [13:0] val;
    logic        known;   // expected result typed in below
    pix_res_t    res;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic        in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  global_tone_map_rgb dut (.*);

  // Predictor state.
  logic        mdl_bypass;
  logic [9:0]  mdl_wr, mdl_wg, mdl_wb;
  logic [13:0] mdl_curve [CURVE_POINTS];

  pix_res_t    pixel_queue [$];
  int          errors;
  int          pixels_seen = 0;
  int          curve_writes;
  int          bypass_pixels;
  int unsigned cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("Timeout at cycle %0d", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [13:0] scale_chan(logic [13:0] ch, logic [13:0] mapped,
                                             logic [13:0] luma);
    logic [31:0] q;
    if (luma == 0) return 14'd0;
    q = (32'(ch) * 32'(mapped)) / 32'(luma);
    return (q > 32'(MAX14)) ? MAX14 : q[13:0];
  endfunction

  function automatic pix_res_t map_pixel(logic [15:0] rin, logic [15:0] gin,
                                         logic [15:0] bin, logic last);
    logic [13:0] r, g, b, luma, mapped;
    logic [31:0] sum;
    int          i0, i1, p0, p1, step;
    pix_res_t    res;
    r = rin[15:2];
    g = gin[15:2];
    b = bin[15:2];
    if (!mdl_bypass) begin
      sum = 32'(r) * mdl_wr + 32'(g) * mdl_wg + 32'(b) * mdl_wb;
      sum = (sum + LUMA_ROUND) >> WEIGHT_SHIFT;
      luma = (sum > 32'(MAX14)) ? MAX14 : sum[13:0];
      i0 = luma >> SEG_SHIFT;
      i1 = (i0 + 1 > CURVE_POINTS - 1) ? CURVE_POINTS - 1 : i0 + 1;
      p0 = mdl_curve[i0];
      p1 = mdl_curve[i1];
      step = (int'(luma[5:0]) * (p1 - p0)) / 64;  // truncates toward zero
      mapped = 14'(p0 + step);
      r = scale_chan(r, mapped, luma);
      g = scale_chan(g, mapped, luma);
      b = scale_chan(b, mapped, luma);
    end
    res.r = {r, 2'b00};
    res.g = {g, 2'b00};
    res.b = {b, 2'b00};
    res.last = last;
    return res;
  endfunction

  task automatic apb_write(reg_idx_t ri, logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 4'(ri) << 2;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (ri)
      REG_BYPASS:  mdl_bypass = data[0];
      REG_RED_W:   mdl_wr = data[9:0];
      REG_GREEN_W: mdl_wg = data[9:0];
      REG_BLUE_W:  mdl_wb = data[9:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(logic byp, logic [9:0] wr, logic [9:0] wg, logic [9:0] wb);
    apb_write(REG_BYPASS, {31'd0, byp});
    apb_write(REG_RED_W, {22'd0, wr});
    apb_write(REG_GREEN_W, {22'd0, wg});
    apb_write(REG_BLUE_W, {22'd0, wb});
  endtask

  // Pause until every pending pixel has come back, then let the pipe drain.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pixel_queue.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // The valid line stays high across back-to-back transactions.
  task automatic send_item(logic kind, logic [15:0] r, logic [15:0] g, logic [15:0] b,
                           logic last, logic [8:0] idx, logic [13:0] val);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tlast <= last;
    in_tdata <= {1'b0, val, idx, b, g, r};
    do @(posedge clk); while (!in_tready);
    if (kind == KIND_CURVE) begin
      curve_writes++;
      if (idx < CURVE_POINTS) mdl_curve[idx] = val;
    end else begin
      pixel_queue = {pixel_queue, map_pixel(r, g, b, last)};
      if (mdl_bypass) bypass_pixels++;
    end
  endtask

  task automatic send_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b, logic last);
    send_item(KIND_PIXEL, r, g, b, last, 9'($urandom), 14'($urandom));
  endtask

  task automatic load_curve(int shape);
    for (int i = 0; i < CURVE_POINTS; i++) begin
      logic [13:0] v;
      case (shape)
        0: v = 14'(i * 64 > 16383 ? 16383 : i * 64);
        1: v = 14'(16383 - i * 63);
        2: v = (i % 2) ? MAX14 : 14'd0;
        default: v = 14'($urandom);
      endcase
      send_item(KIND_CURVE, 16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
                9'(i), v);
    end
  endtask

  // Output side: random backpressure and comparison.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        pix_res_t got, want;
        got = {out_tdata[15:0], out_tdata[31:16], out_tdata[47:32], out_tlast};
        pixels_seen++;
        if (pixel_queue.size() == 0) begin
          $display("%0t: unexpected pixel %h", $time, got);
          errors++;
        end else begin
          want = pixel_queue.pop_front();
          if (got.r !== want.r) begin
            $display("%0t: red expected %h actual %h", $time, want.r, got.r);
            errors++;
          end
          if (got.g !== want.g) begin
            $display("%0t: green expected %h actual %h", $time, want.g, got.g);
            errors++;
          end
          if (got.b !== want.b) begin
            $display("%0t: blue expected %h actual %h", $time, want.b, got.b);
            errors++;
          end
          if (got.last !== want.last) begin
            $display("%0t: frame end expected %b actual %b", $time, want.last, got.last);
            errors++;
          end
        end
      end
      if ($urandom_range(0, 3) == 0) out_tready <= ($urandom_range(0, 5) == 0);
      else out_tready <= (cycle_count % 2000 < 600) ? 1'b1 : ($urandom_range(0, 2) != 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  stim_row_t directed [$];

  task automatic add_row(logic kind, logic [15:0] r, logic [15:0] g, logic [15:0] b,
                         logic last, logic [8:0] idx, logic [13:0] val,
                         logic known, pix_res_t res);
    stim_row_t row;
    row = '{kind, r, g, b, last, idx, val, known, res};
    directed = {directed, row};
  endtask

  initial begin
    stim_row_t row;
    pix_res_t  want;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    in_tlast = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    errors = 0;
    curve_writes = 0;
    bypass_pixels = 0;
    mdl_bypass = 1'b0;
    mdl_wr = 10'd306;
    mdl_wg = 10'd601;
    mdl_wb = 10'd117;
    foreach (mdl_curve[i]) mdl_curve[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: curve ends, ignored out-of-range writes, zero luma, extremes.
    add_row(KIND_CURVE, 0, 0, 0, 0, 9'd0, 14'd0, 0, '0);
    add_row(KIND_CURVE, 0, 0, 0, 0, 9'd1, MAX14, 0, '0);
    add_row(KIND_CURVE, 0, 0, 0, 0, 9'd256, MAX14, 0, '0);
    add_row(KIND_CURVE, 0, 0, 0, 0, 9'd255, 14'd100, 0, '0);
    add_row(KIND_CURVE, 0, 0, 0, 0, 9'd511, 14'd5, 0, '0);
    add_row(KIND_CURVE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 9'd300, 14'h2AAA, 0, '0);

    // Fill the rest of the curve so every lookup hits a written point.
    for (int i = 2; i < 255; i++) begin
      add_row(KIND_CURVE, 0, 0, 0, 0, 9'(i), 14'(i * 64), 0, '0);
    end

    add_row(KIND_PIXEL, 16'h0000, 16'h0000, 16'h0000, 1, 0, 0, 1, '{0, 0, 0, 1});
    add_row(KIND_PIXEL, 16'h0003, 16'h0002, 16'h0001, 0, 0, 0, 1, '{0, 0, 0, 0});
    add_row(KIND_PIXEL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 0, 0, 0, '0);
    add_row(KIND_PIXEL, 16'hFFFF, 16'h0000, 16'h0000, 0, 0, 0, 0, '0);
    add_row(KIND_PIXEL, 16'h0000, 16'h0000, 16'h0100, 0, 0, 0, 0, '0);
    add_row(KIND_PIXEL, 16'h0100, 16'h0100, 16'h0100, 0, 0, 0, 0, '0);
    add_row(KIND_PIXEL, 16'hAAAA, 16'h5555, 16'hFFFC, 1, 0, 0, 0, '0);
    // Rewrite of point 255 leaves a falling slope into point 256.
    add_row(KIND_CURVE, 0, 0, 0, 0, 9'd255, MAX14, 0, '0);
    add_row(KIND_CURVE, 0, 0, 0, 0, 9'd256, 14'd0, 0, '0);
    add_row(KIND_PIXEL, 16'hFFF0, 16'hFFF0, 16'hFFF0, 0, 0, 0, 0, '0);
    add_row(KIND_PIXEL, 16'h0004, 16'h0004, 16'h0004, 1, 0, 0, 0, '0);

    foreach (directed[k]) begin
      row = directed[k];
      if (row.known && row.kind == KIND_PIXEL) begin
        want = map_pixel(row.r, row.g, row.b, row.last);
        if (want !== row.res) begin
          $display("%0t: table row %0d expected %h actual %h", $time, k, row.res, want);
          errors++;
        end
      end
      send_item(row.kind, row.r, row.g, row.b, row.last, row.idx, row.val);
    end
    drain();

    // Random phases, each with its own settings; three reload the curve.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_config(1'b1, 10'd306, 10'd601, 10'd117);
        1: set_config(1'b0, 10'd1023, 10'd1023, 10'd1023);
        2: set_config(1'b0, 10'd0, 10'd0, 10'd0);
        3: set_config(1'b0, 10'd1023, 10'd0, 10'd1);
        default: set_config(($urandom_range(0, 5) == 0), 10'($urandom), 10'($urandom),
                            10'($urandom));
      endcase
      if (ph > 0 && ph < 4) load_curve(ph);
      for (int n = 0; n < 80; n++) begin
        if ($urandom_range(0, 19) == 0) begin
          logic [8:0] idx;
          idx = $urandom_range(0, 3) == 0 ? 9'($urandom_range(257, 511)) : 9'($urandom_range(0, 256));
          send_item(KIND_CURVE, 16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
                    idx, 14'($urandom));
        end else if ($urandom_range(0, 9) == 0) begin
          send_pixel(16'($urandom_range(0, 64)), 16'($urandom_range(0, 64)),
                     16'($urandom_range(0, 64)), 1'($urandom));
        end else begin
          send_pixel(16'($urandom), 16'($urandom), 16'($urandom), ($urandom_range(0, 15) == 0));
        end
        if (n == 40) drain();
      end
      drain();
    end
    set_config(1'b0, 10'd306, 10'd601, 10'd117);
    drain();

    $display("Checked %0d pixels (%0d in bypass) and %0d curve writes.",
             pixels_seen, bypass_pixels, curve_writes);
    $display("Covered directed extremes, eight register settings and random stalls.");
    if (errors == 0 && pixel_queue.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d pixels missing", errors, pixel_queue.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/gtm_pkg.sv
hw/rtl/global_tone_map_rgb.sv
hw/rtl/gtm_chk.sv
tb/sv/tb_global_tone_map_rgb.sv
